### design/dhpid_pkg.sv
// ----------------------------------------------------------------------------
// dhpid_pkg
// Types and constants shared by the distance-hold PID motor drive.
// ----------------------------------------------------------------------------
package dhpid_pkg;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_BASE   = 3'd4,
    REG_LIMIT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] target;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [7:0]  base;
    logic [7:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic [14:0] distance;
    logic [7:0]  duty;
    logic        reverse;
  } res_t;

  localparam logic [11:0] RST_TARGET = 12'd240;
  localparam logic [15:0] RST_KP     = 16'd768;
  localparam logic [15:0] RST_KI     = 16'hFF80;
  localparam logic [15:0] RST_KD     = 16'hFF80;
  localparam logic [7:0]  RST_BASE   = 8'd220;
  localparam logic [7:0]  RST_LIMIT  = 8'd30;

  // 0.01715 cm/us in 1/16 cm, Q16, rounded half up
  localparam logic [30:0] DIST_SCALE = 31'd17983;
  localparam logic [30:0] DIST_ROUND = 31'd32768;

  // output = |num| / 40960 = (|num| >> 13) / 5; quotients of 256 and up all clamp
  localparam int unsigned DIV_SHIFT  = 13;
  localparam logic [10:0] Q_SAT      = 11'd1280;
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

endpackage

### design/dhpid_regs.sv
// ----------------------------------------------------------------------------
// dhpid_regs
// APB register file holding the setpoint, the gains (Kp, Ki Q12) and PWM limits.
// ----------------------------------------------------------------------------
module dhpid_regs
  import dhpid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= RST_TARGET;
      cfg_r.kp     <= RST_KP;
      cfg_r.ki     <= RST_KI;
      cfg_r.kd     <= RST_KD;
      cfg_r.base   <= RST_BASE;
      cfg_r.limit  <= RST_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_TARGET: cfg_r.target <= pwdata[11:0];
        REG_KP:     cfg_r.kp     <= pwdata[15:0];
        REG_KI:     cfg_r.ki     <= pwdata[15:0];
        REG_KD:     cfg_r.kd     <= pwdata[15:0];
        REG_BASE:   cfg_r.base   <= pwdata[7:0];
        REG_LIMIT:  cfg_r.limit  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET: prdata = {20'd0, cfg_r.target};
      REG_KP:     prdata = {{16{cfg_r.kp[15]}}, cfg_r.kp};
      REG_KI:     prdata = {{16{cfg_r.ki[15]}}, cfg_r.ki};
      REG_KD:     prdata = {{16{cfg_r.kd[15]}}, cfg_r.kd};
      REG_BASE:   prdata = {24'd0, cfg_r.base};
      REG_LIMIT:  prdata = {24'd0, cfg_r.limit};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

### design/dhpid_core.sv
// ----------------------------------------------------------------------------
// dhpid_core
// Seven-stage pipeline: echo capture, distance, error and integral, gain products,
// PID sum, magnitude, divide and clamp. A full stage holds while the one after is held.
// ----------------------------------------------------------------------------
module dhpid_core
  import dhpid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_echo,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] v_r, v_nxt, en;

  // stage 0
  logic [15:0] echo_r;
  // stage 1
  logic [30:0] dsum;
  logic [14:0] dist1_r;
  // stage 2
  logic signed [16:0] err17;
  logic signed [15:0] err;
  logic signed [19:0] err10, err10_r;
  logic signed [32:0] isum;
  logic signed [31:0] integ_nxt, integ_r;
  logic signed [15:0] prev_r;
  logic signed [16:0] delta, delta_r;
  logic [14:0]        dist2_r;
  // stage 3
  logic signed [35:0] pp_nxt, pp_r;
  logic signed [47:0] pi_nxt, pi_r;
  logic signed [32:0] pd_nxt, pd_r;
  logic [14:0]        dist3_r;
  // stage 4
  logic [52:0] num_nxt, num_r;
  logic [14:0] dist4_r;
  // stage 5
  logic [52:0] absn;
  logic [39:0] q;
  logic [10:0] qc_nxt, qc_r;
  logic        neg_r;
  logic [14:0] dist5_r;
  // stage 6
  logic [26:0] qm;
  logic [8:0]  quo;
  logic [7:0]  mag;
  logic [8:0]  dsat;
  res_t        res_nxt, res_r;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: distance
  assign dsum = 31'(echo_r) * DIST_SCALE + DIST_ROUND;

  // stage 2: error, saturating integral, change in error
  assign err17 = $signed({5'd0, cfg.target}) - $signed({2'd0, dist1_r});
  assign err   = err17[15:0];
  assign err10 = $signed({{1{err[15]}}, err, 3'd0}) + $signed({{3{err[15]}}, err, 1'b0});
  assign isum  = $signed({integ_r[31], integ_r}) + $signed({{13{err10[19]}}, err10});
  assign delta = $signed({err[15], err}) - $signed({prev_r[15], prev_r});

  always_comb begin
    if (isum[32] != isum[31]) begin
      integ_nxt = isum[32] ? $signed(INT_MIN) : $signed(INT_MAX);
    end else begin
      integ_nxt = isum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (en[2] && v_r[1]) begin
      integ_r <= integ_nxt;
      prev_r  <= err;
    end
  end

  // stage 3: gain products
  assign pp_nxt = $signed(cfg.kp) * err10_r;
  assign pi_nxt = $signed(cfg.ki) * integ_r;
  assign pd_nxt = $signed(cfg.kd) * delta_r;

  // stage 4: 10*Kp*e + 10*Ki*I + Kd*de
  assign num_nxt = {{17{pp_r[35]}}, pp_r}
                 + {{2{pi_r[47]}}, pi_r, 3'd0}
                 + {{4{pi_r[47]}}, pi_r, 1'b0}
                 + {{20{pd_r[32]}}, pd_r};

  // stage 5: magnitude, drop 2^13, clamp ahead of the divide by five
  assign absn = num_r[52] ? (~num_r + 53'd1) : num_r;
  assign q    = absn[52:DIV_SHIFT];

  always_comb begin
    if ((|q[39:11]) || (q[10:0] >= Q_SAT)) begin
      qc_nxt = Q_SAT;
    end else begin
      qc_nxt = q[10:0];
    end
  end

  // stage 6: divide by five, speed clamp, base add
  assign qm   = 27'(qc_r) * 27'(DIV5_RECIP);
  assign quo  = qm[DIV5_SHIFT+8:DIV5_SHIFT];
  assign mag  = (quo > {1'b0, cfg.limit}) ? cfg.limit : quo[7:0];
  assign dsat = {1'b0, cfg.base} + {1'b0, mag};

  always_comb begin
    res_nxt.reverse  = neg_r && (quo != 9'd0);
    res_nxt.duty     = dsat[8] ? 8'hFF : dsat[7:0];
    res_nxt.distance = dist5_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      echo_r <= in_echo;
    end
    if (en[1]) begin
      dist1_r <= dsum[30:16];
    end
    if (en[2]) begin
      err10_r <= err10;
      delta_r <= delta;
      dist2_r <= dist1_r;
    end
    if (en[3]) begin
      pp_r    <= pp_nxt;
      pi_r    <= pi_nxt;
      pd_r    <= pd_nxt;
      dist3_r <= dist2_r;
    end
    if (en[4]) begin
      num_r   <= num_nxt;
      dist4_r <= dist3_r;
    end
    if (en[5]) begin
      qc_r    <= qc_nxt;
      neg_r   <= num_r[52];
      dist5_r <= dist4_r;
    end
    if (en[6]) begin
      res_r <= res_nxt;
    end
  end

endmodule

### design/distance_hold_pid_motor_drive_top.sv
// ----------------------------------------------------------------------------
// distance_hold_pid_motor_drive_top
// Echo time in, motor direction, PWM duty and measured distance out.
// An accepted beat moves through the core's stage registers in order to out_tvalid.
// Throughput is one beat per cycle while out_tready is high, set by the seven-stage
// pipeline in the core. Stages hold independently, so input is taken while a result
// waits until every stage is full.
// Reset (synchronous, rst_n low): pipeline empty, integral and previous
// error zero, registers at their defaults.
// ----------------------------------------------------------------------------
module distance_hold_pid_motor_drive_top
  import dhpid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] echo_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [0] reverse, [8:1] duty, [23:9] distance
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  res_t res;

  assign cfg_pready = 1'b1;

  dhpid_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  dhpid_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_echo   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.distance, res.duty, res.reverse};

  // empty output stage lets the whole pipeline move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with output stage empty");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat straight after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready straight after reset");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distance-hold PID motor drive. Echo beats are
// streamed in with bursty gaps while the result side stalls on its own
// pattern. Each accepted beat runs through a local model of the range
// conversion, saturating integral and PID stage. Each result beat is
// compared with the oldest expected beat. The APB registers are rewritten
// and read back between phases, once the pipeline has drained. The run
// opens with a short table of directed beats. Random phases follow.
// ----------------------------------------------------------------------------
module tb
  import dhpid_pkg::*;
();

  localparam int     WATCHDOG_LIMIT    = 2000;
  localparam int     SETTLE_CYCLES     = 8;
  localparam int     TAIL_CYCLES       = 20;
  localparam int     PROBE_ROWS        = 20;
  localparam int     RANDOM_PHASES     = 6;
  localparam int     PHASE_BEATS       = 250;
  localparam int     REPORT_LIMIT      = 10;
  localparam longint ECHO_SCALE_Q16    = 17983;
  localparam longint ECHO_ROUND        = 32768;
  localparam longint PID_DIVISOR       = 40960;
  localparam int     ECHO_PER_DIST_Q12 = 14927;
  localparam longint INTEG_HI          = 64'sh7FFF_FFFF;
  localparam longint INTEG_LO          = -64'sh8000_0000;
  localparam logic [4:0] ADDR_UNMAPPED = 5'd28;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_BURSTY
  } sink_mode_t;

  typedef struct packed {
    logic [2:0]  cfg_sel;
    logic [15:0] echo;
    logic        typed;
    res_t        want;
  } probe_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;     // [15:0] echo_time
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;    // [0] reverse, [8:1] duty, [23:9] distance
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  distance_hold_pid_motor_drive_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // model copy of the registers and loop state
  cfg_t       drive_set;
  int         prev_err = 0;
  int         integ_acc = 0;
  res_t       pending_drive[$];

  int         fail_count = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  logic       beat_typed = 1'b0;
  res_t       beat_want = '0;

  int unsigned sink_cycle = 0;
  int          sink_hold = 0;
  sink_mode_t  sink_mode = SINK_OPEN;

  cfg_t       probe_cfgs[0:5];
  probe_row_t probe_rows[PROBE_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t predict_drive(input logic [15:0] echo);
    longint meas, err, acc, delta, num, pid, mag, duty;
    res_t   r;
    meas = (longint'(echo) * ECHO_SCALE_Q16 + ECHO_ROUND) >>> 16;
    err  = longint'(drive_set.target) - meas;
    acc  = longint'(integ_acc) + 10 * err;
    if (acc > INTEG_HI) acc = INTEG_HI;
    if (acc < INTEG_LO) acc = INTEG_LO;
    integ_acc = int'(acc);
    delta = err - longint'(prev_err);
    prev_err = int'(err);
    num = 10 * longint'($signed(drive_set.kp)) * err
        + 10 * longint'($signed(drive_set.ki)) * acc
        + longint'($signed(drive_set.kd)) * delta;
    pid = num / PID_DIVISOR;
    mag = (pid < 0) ? -pid : pid;
    if (mag > longint'(drive_set.limit)) mag = longint'(drive_set.limit);
    duty = longint'(drive_set.base) + mag;
    if (duty > 255) duty = 255;
    r.reverse  = (pid < 0);
    r.duty     = duty[7:0];
    r.distance = meas[14:0];
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  function automatic logic [15:0] roll_gain(input int span);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom());
      default: return 16'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic [7:0] roll_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic cfg_t roll_cfg();
    cfg_t c;
    case ($urandom_range(0, 5))
      0: c.target = 12'h000;
      1: c.target = 12'hFFF;
      default: c.target = 12'($urandom());
    endcase
    c.kp    = roll_gain(1024);
    c.ki    = roll_gain(8);
    c.kd    = roll_gain(1024);
    c.base  = roll_byte();
    c.limit = roll_byte();
    return c;
  endfunction

  function automatic logic [15:0] pick_echo();
    int centre, e;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(1 << $urandom_range(0, 15));
      3, 4: return 16'($urandom());
      default: begin
        // hover around the setpoint, leaning so the integral drifts back to zero
        centre = (int'(drive_set.target) * ECHO_PER_DIST_Q12) >>> 12;
        if (integ_acc > 0) e = centre + int'($urandom_range(0, 400)) - 100;
        else e = centre + int'($urandom_range(0, 400)) - 300;
        if (e < 0) e = 0;
        return 16'(e);
      end
    endcase
  endfunction

  task automatic apb_xfer(input logic wr, input logic [4:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    logic [31:0] field, mask, rdata;
    reg_idx_t    r;
    settle_idle();
    for (int i = REG_TARGET; i <= REG_LIMIT; i++) begin
      r = reg_idx_t'(i);
      case (r)
        REG_TARGET: begin field = {20'd0, c.target}; mask = 32'h0000_0FFF; end
        REG_KP:     begin field = {16'd0, c.kp};     mask = 32'h0000_FFFF; end
        REG_KI:     begin field = {16'd0, c.ki};     mask = 32'h0000_FFFF; end
        REG_KD:     begin field = {16'd0, c.kd};     mask = 32'h0000_FFFF; end
        REG_BASE:   begin field = {24'd0, c.base};   mask = 32'h0000_00FF; end
        REG_LIMIT:  begin field = {24'd0, c.limit};  mask = 32'h0000_00FF; end
        default:    begin field = '0;                mask = '0;            end
      endcase
      // junk in the unused upper bits must be dropped
      apb_xfer(1'b1, {r, 2'b00}, ($urandom() & ~mask) | field, rdata);
      apb_xfer(1'b0, {r, 2'b00}, 32'd0, rdata);
      if ((rdata & mask) !== field)
        note_mismatch($sformatf("register %s read back %h, wrote %h",
                                r.name(), rdata & mask, field));
    end
    // unmapped address, write has to be ignored
    apb_xfer(1'b1, ADDR_UNMAPPED, $urandom(), rdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    drive_set = c;
  endtask

  task automatic send_echo(input logic [15:0] echo, input logic typed, input res_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid  <= 1'b1;
    in_tdata   <= echo;
    beat_typed = typed;
    beat_want  = want;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic probe_row_t probe(input int sel, input int echo, input logic typed,
                                       input int dist_q4, input int duty, input logic rev);
    probe_row_t p;
    p.cfg_sel          = 3'(sel);
    p.echo             = 16'(echo);
    p.typed            = typed;
    p.want.distance    = 15'(dist_q4);
    p.want.duty        = 8'(duty);
    p.want.reverse     = rev;
    return p;
  endfunction

  always @(negedge clk) begin
    if (sink_cycle % 256 == 0) sink_mode = sink_mode_t'($urandom_range(0, 3));
    sink_cycle++;
    case (sink_mode)
      SINK_OPEN:     out_tready <= 1'b1;
      SINK_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: out_tready <= ((sink_cycle % 7) < 4);
      default: begin
        if (sink_hold > 0) begin
          sink_hold--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) sink_hold = $urandom_range(1, 16);
        end
      end
    endcase
  end

  always @(posedge clk) begin : watch
    res_t got, want;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = out_tdata;
        if (pending_drive.size() == 0) begin
          note_mismatch($sformatf("unexpected beat: rev %0b duty %0d dist %0d",
                                  got.reverse, got.duty, got.distance));
        end else begin
          want = pending_drive.pop_front();
          if (got.reverse !== want.reverse || got.duty !== want.duty ||
              got.distance !== want.distance)
            note_mismatch($sformatf(
              "result mismatch: want rev %0b duty %0d dist %0d, got rev %0b duty %0d dist %0d",
              want.reverse, want.duty, want.distance, got.reverse, got.duty, got.distance));
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        want = predict_drive(in_tdata);
        pending_drive.push_back(beat_typed ? beat_want : want);
      end
      if (cfg_psel && cfg_penable && cfg_pready) moved = 1'b1;
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("distance_hold_pid_motor_drive_top verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    drive_set = '{target: RST_TARGET, kp: RST_KP, ki: RST_KI, kd: RST_KD,
                  base: RST_BASE, limit: RST_LIMIT};

    probe_cfgs[0] = drive_set;
    // gains off: zero output, forward, duty is the base
    probe_cfgs[1] = '{target: 12'd0,    kp: 16'h0000, ki: 16'h0000, kd: 16'h0000,
                      base: 8'd0,       limit: 8'd255};
    // largest positive P gain, base and speed overflow 255
    probe_cfgs[2] = '{target: 12'd4095, kp: 16'h7FFF, ki: 16'h0000, kd: 16'h0000,
                      base: 8'd255,     limit: 8'd255};
    // most negative P gain, speed clamped to nothing
    probe_cfgs[3] = '{target: 12'd4095, kp: 16'h8000, ki: 16'h0000, kd: 16'h0000,
                      base: 8'd200,     limit: 8'd0};
    probe_cfgs[4] = '{target: 12'd2048, kp: 16'h0000, ki: 16'h7FFF, kd: 16'h8000,
                      base: 8'd100,     limit: 8'd50};
    probe_cfgs[5] = '{target: 12'd1000, kp: 16'h0000, ki: 16'h0000, kd: 16'h7FFF,
                      base: 8'd128,     limit: 8'd127};

    probe_rows = '{
      probe(0, 0,     1'b1, 0,     250, 1'b1),
      probe(0, 65535, 1'b0, 0,     0,   1'b0),
      probe(0, 1400,  1'b0, 0,     0,   1'b0),
      probe(1, 0,     1'b1, 0,     0,   1'b0),
      probe(0, 65535, 1'b1, 17983, 0,   1'b0),
      probe(0, 1,     1'b1, 0,     0,   1'b0),
      probe(0, 2,     1'b1, 1,     0,   1'b0),
      probe(0, 32768, 1'b1, 8992,  0,   1'b0),
      probe(2, 0,     1'b1, 0,     255, 1'b0),
      probe(0, 65535, 1'b1, 17983, 255, 1'b1),
      probe(3, 0,     1'b1, 0,     200, 1'b1),
      probe(0, 65535, 1'b1, 17983, 200, 1'b0),
      probe(4, 0,     1'b0, 0,     0,   1'b0),
      probe(0, 65535, 1'b0, 0,     0,   1'b0),
      probe(0, 7463,  1'b0, 0,     0,   1'b0),
      probe(0, 12000, 1'b0, 0,     0,   1'b0),
      probe(5, 0,     1'b0, 0,     0,   1'b0),
      probe(0, 65535, 1'b0, 0,     0,   1'b0),
      probe(0, 0,     1'b0, 0,     0,   1'b0),
      probe(0, 30000, 1'b0, 0,     0,   1'b0)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PROBE_ROWS; i++) begin
      if (probe_rows[i].cfg_sel != 0) apply_cfg(probe_cfgs[probe_rows[i].cfg_sel]);
      send_echo(probe_rows[i].echo, probe_rows[i].typed, probe_rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_cfg(roll_cfg());
      for (int n = 0; n < PHASE_BEATS; n++) send_echo(pick_echo(), 1'b0, '0);
    end

    settle_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("distance_hold_pid_motor_drive_top verification clean");
    end else begin
      $display("distance_hold_pid_motor_drive_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/dhpid_pkg.sv
design/dhpid_regs.sv
design/dhpid_core.sv
design/distance_hold_pid_motor_drive_top.sv
sim/tb.sv
